### rtl/blt_pkg.sv
// Package for the binary trie longest prefix match unit.
// Holds the node pool sizes, field widths, opcodes and the node record type.
// Depends on nothing; every other file but blt_node_ram uses it by scoped names.
`default_nettype none

package blt_pkg;

   localparam int NODES    = 4096;
   localparam int HOP_W    = 16;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int IDX_W    = $clog2(NODES);
   localparam int CNT_W    = IDX_W + 1;
   localparam int MAX_DEPTH = 32;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_POOL_FULL = 1'b1
   } status_type;

   typedef struct packed {
      logic [HOP_W-1:0] hop;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
   } node_type;

   localparam int NODE_W = $bits(node_type);

endpackage

`default_nettype wire

### rtl/blt_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on blt_pkg for the payload widths.
`default_nettype none

interface blt_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [blt_pkg::ADDR_W-1:0] address;
   logic [blt_pkg::LEN_W-1:0]  prefix_len;
   logic [blt_pkg::HOP_W-1:0]  next_hop;

   modport source (output valid, operation, address, prefix_len, next_hop, input ready);
   modport sink   (input valid, operation, address, prefix_len, next_hop, output ready);
endinterface

interface blt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [blt_pkg::HOP_W-1:0] match_hop;
   logic                      status;
   logic [blt_pkg::CNT_W-1:0] nodes_used;

   modport source (output valid, match_hop, status, nodes_used, input ready);
   modport sink   (input valid, match_hop, status, nodes_used, output ready);
endinterface

`default_nettype wire

### rtl/blt_node_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used as the trie node pool; no dependencies.
`default_nettype none

module blt_node_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/blt_walker.sv
// Trie walk sequencer: one node visited per cycle, insert allocation and link
// writes, and the response register. Depends on blt_pkg and blt_if.
`default_nettype none

module blt_walker (
   input  wire logic                    clock,
   input  wire logic                    reset,
   blt_req_if.sink                      req_ch,
   blt_rsp_if.source                    rsp_ch,
   output logic                         mem_wr_en,
   output logic [blt_pkg::IDX_W-1:0]    mem_wr_addr,
   output blt_pkg::node_type            mem_wr_data,
   output logic                         mem_rd_en,
   output logic [blt_pkg::IDX_W-1:0]    mem_rd_addr,
   input  wire blt_pkg::node_type       mem_rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   blt_pkg::op_type             op_ff, op_in;
   logic [blt_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [blt_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [blt_pkg::LEN_W-1:0]   depth_ff, depth_in;
   logic [blt_pkg::HOP_W-1:0]   hop_ff, hop_in;
   logic [blt_pkg::HOP_W-1:0]   best_ff, best_in;
   logic [blt_pkg::IDX_W-1:0]   cur_ff, cur_in;
   logic [blt_pkg::CNT_W-1:0]   alloc_ff, alloc_in;
   blt_pkg::status_type         status_ff, status_in;
   logic                        fresh_ff, fresh_in;
   logic                        rd_root_ff, rd_root_in;
   logic                        root_written_ff, root_written_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [blt_pkg::HOP_W-1:0]   rsp_hop_ff, rsp_hop_in;
   blt_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [blt_pkg::CNT_W-1:0]   rsp_used_ff, rsp_used_in;

   blt_pkg::node_type           node;
   logic [blt_pkg::IDX_W-1:0]   child;
   logic [blt_pkg::IDX_W-1:0]   fresh_idx;
   logic [blt_pkg::HOP_W-1:0]   hop_seen;
   logic                        at_end;
   logic                        pool_full;
   logic                        go_right;

   // A freshly allocated node is known to be empty, so it is not read back.
   // The root reads as empty until its first write.
   always_comb begin
      if (fresh_ff || (rd_root_ff && !root_written_ff)) begin
         node = '0;
      end else begin
         node = mem_rd_data;
      end
   end

   assign go_right  = addr_ff[blt_pkg::ADDR_W-1];
   assign child     = go_right ? node.right : node.left;
   assign at_end    = (depth_ff == len_ff);
   assign pool_full = (alloc_ff >= blt_pkg::CNT_W'(blt_pkg::NODES));
   assign fresh_idx = alloc_ff[blt_pkg::IDX_W-1:0];
   assign hop_seen  = (node.hop != '0) ? node.hop : best_ff;

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.match_hop  = rsp_hop_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.nodes_used = rsp_used_ff;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      addr_in         = addr_ff;
      len_in          = len_ff;
      depth_in        = depth_ff;
      hop_in          = hop_ff;
      best_in         = best_ff;
      cur_in          = cur_ff;
      alloc_in        = alloc_ff;
      status_in       = status_ff;
      fresh_in        = fresh_ff;
      rd_root_in      = rd_root_ff;
      root_written_in = root_written_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_hop_in      = rsp_hop_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_used_in     = rsp_used_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = cur_ff;
      mem_wr_data = node;
      mem_rd_en   = 1'b0;
      mem_rd_addr = child;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in      = blt_pkg::op_type'(req_ch.operation);
               addr_in    = req_ch.address;
               hop_in     = req_ch.next_hop;
               if (req_ch.prefix_len > blt_pkg::LEN_W'(blt_pkg::MAX_DEPTH)) begin
                  len_in = blt_pkg::LEN_W'(blt_pkg::MAX_DEPTH);
               end else begin
                  len_in = req_ch.prefix_len;
               end
               depth_in    = '0;
               cur_in      = '0;
               best_in     = '0;
               status_in   = blt_pkg::STATUS_OK;
               fresh_in    = 1'b0;
               rd_root_in  = 1'b1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = '0;
               state_in    = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (op_ff == blt_pkg::OP_LOOKUP) begin
               best_in = hop_seen;
               if (at_end || child == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  mem_rd_en  = 1'b1;
                  rd_root_in = 1'b0;
                  fresh_in   = 1'b0;
                  cur_in     = child;
                  depth_in   = depth_ff + 1'b1;
                  addr_in    = addr_ff << 1;
               end
            end else begin
               priority if (at_end) begin
                  mem_wr_en       = 1'b1;
                  mem_wr_data.hop = hop_ff;
                  state_in        = ST_FINISH;
               end else if (child != '0) begin
                  mem_rd_en  = 1'b1;
                  rd_root_in = 1'b0;
                  fresh_in   = 1'b0;
                  cur_in     = child;
                  depth_in   = depth_ff + 1'b1;
                  addr_in    = addr_ff << 1;
               end else if (pool_full) begin
                  // Write the node back as is, so a fresh node still gets stored.
                  mem_wr_en = 1'b1;
                  status_in = blt_pkg::STATUS_POOL_FULL;
                  state_in  = ST_FINISH;
               end else begin
                  mem_wr_en = 1'b1;
                  if (go_right) begin
                     mem_wr_data.right = fresh_idx;
                  end else begin
                     mem_wr_data.left = fresh_idx;
                  end
                  cur_in     = fresh_idx;
                  alloc_in   = alloc_ff + 1'b1;
                  fresh_in   = 1'b1;
                  rd_root_in = 1'b0;
                  depth_in   = depth_ff + 1'b1;
                  addr_in    = addr_ff << 1;
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_hop_in    = (op_ff == blt_pkg::OP_INSERT) ? '0 : best_ff;
               rsp_status_in = status_ff;
               rsp_used_in   = alloc_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (mem_wr_en && mem_wr_addr == '0) begin
         root_written_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         alloc_ff        <= blt_pkg::CNT_W'(1);
         root_written_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         alloc_ff        <= alloc_in;
         root_written_ff <= root_written_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      depth_ff      <= depth_in;
      hop_ff        <= hop_in;
      best_ff       <= best_in;
      cur_ff        <= cur_in;
      status_ff     <= status_in;
      fresh_ff      <= fresh_in;
      rd_root_ff    <= rd_root_in;
      rsp_hop_ff    <= rsp_hop_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

endmodule

`default_nettype wire

### rtl/binary_trie_longest_prefix_match_unit.sv
// Top level of the binary trie longest prefix match unit.
// Depends on blt_pkg, blt_if, blt_node_ram and blt_walker.
//
//   channel  direction  payload
//   req_ch   in         operation, address, prefix_len, next_hop
//   rsp_ch   out        match_hop, status, nodes_used
//
// Each item runs in order: the request is accepted and the root read issued,
// each node on the path is visited through the single read port of the node
// pool, and the response register is loaded. At most 32 child links are
// followed. A new request is accepted only once the previous item has loaded
// its response register.
// Reset is synchronous; it empties the trie (root only) and drops any held
// response. No pool clearing pass is needed after reset.
// A stalled response is held in its register; the walk of the next item may
// run meanwhile and waits only to hand over its own response.
`default_nettype none

module binary_trie_longest_prefix_match_unit (
   input wire logic  clock,
   input wire logic  reset,
   blt_req_if.sink   req_ch,
   blt_rsp_if.source rsp_ch
);

   logic                      mem_wr_en;
   logic [blt_pkg::IDX_W-1:0] mem_wr_addr;
   blt_pkg::node_type         mem_wr_data;
   logic                      mem_rd_en;
   logic [blt_pkg::IDX_W-1:0] mem_rd_addr;
   blt_pkg::node_type         mem_rd_data;

   blt_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   blt_node_ram #(
      .WIDTH (blt_pkg::NODE_W),
      .DEPTH (blt_pkg::NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for binary_trie_longest_prefix_match_unit.
// Depends on blt_pkg and the blt_req_if / blt_rsp_if channel interfaces.
// Keeps its own copy of the trie, predicts every response and checks it in order.
`timescale 1ns / 1ps

module testbench;

   localparam int STUCK_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int HOLD_AT     = 300;
   localparam int END_SETTLE  = 40;

   typedef struct {
      blt_pkg::op_type op;
      logic [31:0]     addr;
      logic [5:0]      len;
      logic [15:0]     hop;
      int              gap;
      bit              drain;
   } route_request_type;

   typedef struct {
      logic [blt_pkg::HOP_W-1:0] match_hop;
      blt_pkg::status_type       status;
      logic [blt_pkg::CNT_W-1:0] nodes_used;
   } trie_answer_type;

   logic clock;
   logic reset;

   blt_req_if req_ch ();
   blt_rsp_if rsp_ch ();

   binary_trie_longest_prefix_match_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the node pool.
   logic [blt_pkg::HOP_W-1:0] trie_hop   [blt_pkg::NODES];
   logic [blt_pkg::IDX_W-1:0] trie_left  [blt_pkg::NODES];
   logic [blt_pkg::IDX_W-1:0] trie_right [blt_pkg::NODES];
   int                        trie_count;

   route_request_type route_requests [$];
   trie_answer_type   trie_answers [$];
   logic [31:0]       known_addr [$];
   int                known_len [$];

   bit                quiet_gaps;
   int                mismatches;
   int                sent_count;
   int                rsp_count;
   int                req_wait;
   bit                req_busy;
   route_request_type next_req;
   trie_answer_type   predicted;
   trie_answer_type   want;
   int                stall_left;
   int                hold_left;
   bit                long_hold_done;
   int                stall_max;
   int                rsp_draw;
   int                stuck_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned exp_v);
      $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_v);
      mismatches++;
   endtask

   // Applies one request to the shadow trie and returns the response it must give.
   task automatic walk_trie(input blt_pkg::op_type op, input logic [31:0] addr,
                            input logic [5:0] len_in, input logic [15:0] hop,
                            output trie_answer_type ans);
      int  len;
      int  depth;
      int  cur;
      int  nxt;
      bit  stop;
      len  = (len_in > blt_pkg::MAX_DEPTH) ? blt_pkg::MAX_DEPTH : int'(len_in);
      cur  = 0;
      stop = 1'b0;
      ans.match_hop = '0;
      ans.status    = blt_pkg::STATUS_OK;
      if (op == blt_pkg::OP_INSERT) begin
         for (depth = 0; depth < len && !stop; depth++) begin
            nxt = addr[31-depth] ? trie_right[cur] : trie_left[cur];
            if (nxt == 0) begin
               if (trie_count >= blt_pkg::NODES) begin
                  stop = 1'b1;
               end else begin
                  nxt = trie_count;
                  trie_hop[nxt]   = '0;
                  trie_left[nxt]  = '0;
                  trie_right[nxt] = '0;
                  if (addr[31-depth])
                     trie_right[cur] = nxt[blt_pkg::IDX_W-1:0];
                  else
                     trie_left[cur] = nxt[blt_pkg::IDX_W-1:0];
                  trie_count++;
               end
            end
            if (!stop)
               cur = nxt;
         end
         if (stop)
            ans.status = blt_pkg::STATUS_POOL_FULL;
         else
            trie_hop[cur] = hop;
      end else begin
         // The walk ends at the clamped prefix length (at most depth 32) or at the first missing child.
         for (depth = 0; depth <= len && !stop; depth++) begin
            if (trie_hop[cur] != 0)
               ans.match_hop = trie_hop[cur];
            if (depth == blt_pkg::MAX_DEPTH) begin
               stop = 1'b1;
            end else begin
               nxt = addr[31-depth] ? trie_right[cur] : trie_left[cur];
               if (nxt == 0)
                  stop = 1'b1;
               else
                  cur = nxt;
            end
         end
      end
      ans.nodes_used = trie_count[blt_pkg::CNT_W-1:0];
   endtask

   function automatic logic [31:0] prefix_mask(input int len);
      logic [31:0] ones;
      ones = 32'hFFFF_FFFF;
      return (len == 0) ? 32'h0 : (ones << (32 - len));
   endfunction

   function automatic void add_request(input blt_pkg::op_type op, input logic [31:0] addr,
                                       input logic [5:0] len, input logic [15:0] hop,
                                       input bit drain);
      route_request_type r;
      r.op    = op;
      r.addr  = addr;
      r.len   = len;
      r.hop   = hop;
      r.gap   = quiet_gaps ? 0 : $urandom_range(0, 5);
      r.drain = drain;
      route_requests.push_back(r);
      if (op == blt_pkg::OP_INSERT && hop != 0) begin
         known_addr.push_back(addr);
         known_len.push_back((len > blt_pkg::MAX_DEPTH) ? blt_pkg::MAX_DEPTH : int'(len));
      end
   endfunction

   // Mostly extends a known route by a few bits, so the pool fills slowly.
   function automatic void add_random_insert(input int max_extra);
      int          pick;
      int          eff;
      logic [31:0] keep;
      logic [31:0] addr;
      logic [5:0]  len;
      logic [15:0] hop;
      if (known_addr.size() != 0 && $urandom_range(0, 9) < 7) begin
         pick = $urandom_range(0, known_addr.size() - 1);
         keep = prefix_mask(known_len[pick]);
         eff  = known_len[pick] + $urandom_range(0, max_extra);
         if (eff > blt_pkg::MAX_DEPTH)
            eff = blt_pkg::MAX_DEPTH;
         addr = (known_addr[pick] & keep) | ($urandom & ~keep);
         len  = 6'(eff);
      end else begin
         addr = $urandom;
         len  = 6'($urandom_range(0, 24));
      end
      if ($urandom_range(0, 15) == 0)
         len = 6'($urandom_range(25, 63));
      hop = ($urandom_range(0, 19) == 0) ? 16'h0 : 16'($urandom);
      add_request(blt_pkg::OP_INSERT, addr, len, hop, 1'b0);
   endfunction

   // Mostly looks up addresses under a known route with a random tail.
   function automatic void add_random_lookup();
      int          pick;
      logic [31:0] keep;
      logic [31:0] addr;
      logic [5:0]  len;
      if (known_addr.size() != 0 && $urandom_range(0, 4) != 0) begin
         pick = $urandom_range(0, known_addr.size() - 1);
         keep = prefix_mask(known_len[pick]);
         addr = (known_addr[pick] & keep) | ($urandom & ~keep);
      end else begin
         addr = $urandom;
      end
      len = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(16, 32));
      add_request(blt_pkg::OP_LOOKUP, addr, len, 16'($urandom), 1'b0);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_wait     <= 0;
         sent_count   <= 0;
      end else begin
         req_busy = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            walk_trie(blt_pkg::op_type'(req_ch.operation), req_ch.address,
                      req_ch.prefix_len, req_ch.next_hop, predicted);
            trie_answers.push_back(predicted);
            sent_count <= sent_count + 1;
            req_busy = 1'b0;
         end
         if (!req_busy) begin
            if (route_requests.size() != 0 && req_wait >= route_requests[0].gap &&
                !(route_requests[0].drain && trie_answers.size() != 0)) begin
               next_req = route_requests.pop_front();
               req_ch.valid      <= 1'b1;
               req_ch.operation  <= next_req.op;
               req_ch.address    <= next_req.addr;
               req_ch.prefix_len <= next_req.len;
               req_ch.next_hop   <= next_req.hop;
               req_wait          <= 0;
            end else begin
               req_ch.valid <= 1'b0;
               if (route_requests.size() != 0)
                  req_wait <= req_wait + 1;
            end
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready   <= 1'b0;
         stall_left     <= 0;
         hold_left      <= 0;
         long_hold_done <= 1'b0;
         rsp_count      <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_count <= rsp_count + 1;
            if (trie_answers.size() == 0) begin
               report_mismatch("response with nothing outstanding", rsp_ch.nodes_used, 0);
            end else begin
               want = trie_answers.pop_front();
               if (rsp_ch.match_hop !== want.match_hop)
                  report_mismatch("match_hop", rsp_ch.match_hop, want.match_hop);
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", rsp_ch.status, want.status);
               if (rsp_ch.nodes_used !== want.nodes_used)
                  report_mismatch("nodes_used", rsp_ch.nodes_used, want.nodes_used);
            end
         end
         stall_max = ((rsp_count / 70) % 3 == 1) ? 0 : 5;
         // The long hold lets the unit fill up and push back on its request side.
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
         end else if (!long_hold_done && sent_count >= HOLD_AT) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            rsp_ch.ready   <= 1'b0;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_draw = $urandom_range(0, stall_max);
            stall_left   <= rsp_draw;
            rsp_ch.ready <= (rsp_draw == 0);
         end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= (stall_left == 1);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("[binary_trie_longest_prefix_match_unit] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int k;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.operation  = 1'b0;
      req_ch.address    = '0;
      req_ch.prefix_len = '0;
      req_ch.next_hop   = '0;
      rsp_ch.ready      = 1'b0;
      stuck_cycles      = 0;
      mismatches        = 0;
      trie_count        = 1;
      trie_hop[0]       = '0;
      trie_left[0]      = '0;
      trie_right[0]     = '0;
      quiet_gaps        = 1'b0;

      // Directed part: empty trie, root route, full depth, long lengths, removal.
      add_request(blt_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0,  16'h0000, 1'b0);
      add_request(blt_pkg::OP_INSERT, 32'h0000_0000, 6'd0,  16'hFFFF, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1'b0);
      add_request(blt_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h0001, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd32, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 6'd32, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd31, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_INSERT, 32'h0000_0000, 6'd40, 16'h8000, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'h0000_0000, 6'd32, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_INSERT, 32'hC0A8_0000, 6'd16, 16'h1234, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hC0A8_0101, 6'd32, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_INSERT, 32'hC0A8_0100, 6'd24, 16'h0042, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hC0A8_01FF, 6'd33, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hC0A8_01FF, 6'd20, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_INSERT, 32'hC0A8_0100, 6'd24, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hC0A8_01FF, 6'd32, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_INSERT, 32'h0000_0000, 6'd0,  16'h0000, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'h1234_5678, 6'd32, 16'h0000, 1'b0);
      add_request(blt_pkg::OP_INSERT, 32'h8000_0000, 6'd1,  16'h5555, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hAAAA_AAAA, 6'd1,  16'h0000, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'hAAAA_AAAA, 6'd0,  16'h0000, 1'b0);
      add_request(blt_pkg::OP_LOOKUP, 32'h5555_5555, 6'd63, 16'hAAAA, 1'b0);

      // Routes grow slowly; lookups mostly fall under known routes.
      for (k = 0; k < 420; k++) begin
         quiet_gaps = ((k / 60) % 3) == 1;
         if ($urandom_range(0, 9) < 4)
            add_random_insert(8);
         else
            add_random_lookup();
      end

      // Long random prefixes until the pool runs out, after a full drain.
      quiet_gaps = 1'b0;
      add_request(blt_pkg::OP_INSERT, $urandom, 6'($urandom_range(32, 63)),
                  16'($urandom), 1'b1);
      for (k = 0; k < 150; k++) begin
         quiet_gaps = ((k / 50) % 2) == 1;
         if ($urandom_range(0, 19) < 17)
            add_request(blt_pkg::OP_INSERT, $urandom, 6'($urandom_range(32, 63)),
                        16'($urandom), 1'b0);
         else
            add_random_lookup();
      end

      // With the pool full, inserts on existing paths still succeed.
      quiet_gaps = 1'b0;
      add_request(blt_pkg::OP_LOOKUP, $urandom, 6'd32, 16'($urandom), 1'b1);
      for (k = 0; k < 340; k++) begin
         quiet_gaps = ((k / 60) % 3) == 2;
         if ($urandom_range(0, 9) < 4)
            add_random_insert(4);
         else
            add_random_lookup();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (route_requests.size() != 0 || req_ch.valid || trie_answers.size() != 0)
         @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);

      if (mismatches == 0)
         $display("[binary_trie_longest_prefix_match_unit] OK");
      else
         $display("[binary_trie_longest_prefix_match_unit] ERROR");
      $finish;
   end

endmodule

### files.f
rtl/blt_pkg.sv
rtl/blt_if.sv
rtl/blt_node_ram.sv
rtl/blt_walker.sv
rtl/binary_trie_longest_prefix_match_unit.sv
verif/testbench.sv
